// File: rtl/core/mbrx_pkg.sv
// Package for the Modbus RTU response receiver: constants, codes, state
// and result types, and the byte-wise CRC-16 step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbrx_pkg;

    localparam int MAX_REGS    = 12;
    localparam int STORE_DEPTH = 29;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam logic [4:0] EXC_LEN = 5'd5;
    localparam logic [4:0] MAX_LEN = 5'd29;

    localparam logic [STORE_AW-1:0] WORD_BASE = STORE_AW'(3);

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_EXCEPTION = 3'd1;
    localparam logic [2:0] STAT_MISMATCH  = 3'd2;
    localparam logic [2:0] STAT_CRC_ERR   = 3'd3;
    localparam logic [2:0] STAT_COUNT_ERR = 3'd4;
    localparam logic [2:0] STAT_TIMEOUT   = 3'd5;

    localparam logic CFG_SLAVE_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h60;
    localparam logic [15:0] TIMEOUT_RST    = 16'd400;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] TICK_MAX       = 16'hFFFF;

    localparam logic [6:0] FN_READ_HOLDING = 7'd3;
    localparam logic [6:0] FN_READ_INPUT   = 7'd4;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_RD_HI,
        ST_RD_LO,
        ST_PUT
    } rx_state_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  exception_code;
        logic [15:0] reg_word;
        logic [3:0]  word_index;
        logic        last;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/mbrx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mbrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/modbus_rtu_response_receiver.sv
// Modbus RTU response receiver: frame check, CRC-16, register word run.
// Latency: a status result is registered at the edge that accepts its item.
// Throughput: one item per cycle unless the output stalls; after a good read
// response, words step RD_HI, RD_LO (RAM reads), PUT; input held off till done.
// Reset: idle, slave_address 96, timeout_ticks 400; frame RAM not cleared.
// Depends on mbrx_pkg and mbrx_ram.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], function_code[14:8],
                                        // expected_length[19:15], zero pad
    input  wire logic [1:0]  s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // exception_code[7:0], reg_word[23:8],
                                        // word_index[27:24], zero pad
    output logic      [2:0]  m_tuser,   // status
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    import mbrx_pkg::*;

    rx_state_t state_reg, state_next;
    logic                busy_reg, busy_next;
    logic [4:0]          byte_count_reg, byte_count_next;
    logic [15:0]         crc_reg, crc_next;
    logic [15:0]         elapsed_reg, elapsed_next;
    logic [6:0]          want_fn_reg, want_fn_next;
    logic [4:0]          want_len_reg, want_len_next;
    logic [7:0]          fs0_reg, fs0_next;
    logic [7:0]          fs1_reg, fs1_next;
    logic [7:0]          fs2_reg, fs2_next;
    logic [7:0]          prev_reg, prev_next;
    logic [3:0]          word_cnt_reg, word_cnt_next;
    logic [3:0]          word_k_reg, word_k_next;
    logic [7:0]          word_hi_reg, word_hi_next;
    logic [7:0]          slave_addr_reg;
    logic [15:0]         timeout_reg;
    logic                m_valid_reg;
    result_t             out_reg;
    result_t             res;
    logic                res_load;

    logic                in_fire;
    logic                slot_free;
    logic [7:0]          in_byte;
    logic [6:0]          in_fn;
    logic [4:0]          in_len;

    logic                ram_we;
    logic                ram_re;
    logic [STORE_AW-1:0] ram_waddr;
    logic [STORE_AW-1:0] ram_raddr;
    logic [STORE_AW-1:0] hi_addr;
    logic [7:0]          ram_rdata;

    assign in_byte   = s_tdata[7:0];
    assign in_fn     = s_tdata[14:8];
    assign in_len    = s_tdata[19:15];
    assign slot_free = !m_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign hi_addr   = WORD_BASE + STORE_AW'({word_k_reg, 1'b0});
    assign cfg_ready = 1'b1;

    mbrx_ram #(
        .WIDTH(8),
        .DEPTH(STORE_DEPTH)
    ) u_frame_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(in_byte),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // next state and datapath
    always_comb
    begin
        logic [4:0] got;
        logic [4:0] needed;
        logic [7:0] fn_byte;
        logic [7:0] exc_fc;
        logic [3:0] cnt;
        logic [15:0] ticks;

        state_next      = state_reg;
        busy_next       = busy_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        elapsed_next    = elapsed_reg;
        want_fn_next    = want_fn_reg;
        want_len_next   = want_len_reg;
        fs0_next        = fs0_reg;
        fs1_next        = fs1_reg;
        fs2_next        = fs2_reg;
        prev_next       = prev_reg;
        word_cnt_next   = word_cnt_reg;
        word_k_next     = word_k_reg;
        word_hi_next    = word_hi_reg;
        res             = '0;
        res.last        = 1'b1;
        res_load        = 1'b0;

        got     = byte_count_reg + 5'd1;
        exc_fc  = {1'b1, want_fn_reg};
        fn_byte = (byte_count_reg == 5'd1) ? in_byte : fs1_reg;
        needed  = (got >= 5'd2 && fn_byte == exc_fc) ? EXC_LEN : want_len_reg;
        cnt     = 4'((want_len_reg - EXC_LEN) >> 1);
        ticks   = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

        unique case (state_reg)
            ST_RECV:
            begin
                if (in_fire)
                begin
                    priority if (s_tuser == KIND_START)
                    begin
                        want_fn_next    = in_fn;
                        want_len_next   = (in_len < EXC_LEN) ? EXC_LEN :
                                          (in_len > MAX_LEN) ? MAX_LEN : in_len;
                        byte_count_next = 5'd0;
                        crc_next        = CRC_INIT;
                        elapsed_next    = 16'd0;
                        busy_next       = 1'b1;
                    end
                    else if (busy_reg && s_tuser == KIND_TICK)
                    begin
                        elapsed_next = ticks;
                        if (ticks >= timeout_reg)
                        begin
                            busy_next  = 1'b0;
                            res.status = STAT_TIMEOUT;
                            res_load   = 1'b1;
                        end
                    end
                    else if (busy_reg && s_tuser == KIND_BYTE)
                    begin
                        if (byte_count_reg >= want_len_reg)
                        begin
                            busy_next  = 1'b0;
                            res.status = STAT_MISMATCH;
                            res_load   = 1'b1;
                        end
                        else
                        begin
                            byte_count_next = got;
                            prev_next       = in_byte;
                            if (byte_count_reg == 5'd0)
                            begin
                                fs0_next = in_byte;
                            end
                            if (byte_count_reg == 5'd1)
                            begin
                                fs1_next = in_byte;
                            end
                            if (byte_count_reg == 5'd2)
                            begin
                                fs2_next = in_byte;
                            end
                            if ({1'b0, byte_count_reg} + 6'd2 < {1'b0, needed})
                            begin
                                crc_next = crc16_byte(crc_reg, in_byte);
                            end

                            if (got == 5'd2 && (fs0_reg != slave_addr_reg ||
                                (in_byte != {1'b0, want_fn_reg} && in_byte != exc_fc)))
                            begin
                                busy_next  = 1'b0;
                                res.status = STAT_MISMATCH;
                                res_load   = 1'b1;
                            end
                            else if (got == needed)
                            begin
                                busy_next = 1'b0;
                                if (prev_reg != crc_reg[7:0] || in_byte != crc_reg[15:8])
                                begin
                                    res.status = STAT_CRC_ERR;
                                    res_load   = 1'b1;
                                end
                                else if (fs1_reg[7])
                                begin
                                    res.status         = STAT_EXCEPTION;
                                    res.exception_code = fs2_reg;
                                    res_load           = 1'b1;
                                end
                                else if (want_fn_reg == FN_READ_HOLDING ||
                                         want_fn_reg == FN_READ_INPUT)
                                begin
                                    if (cnt == 4'd0 || cnt > 4'(MAX_REGS) ||
                                        fs2_reg != {3'b000, cnt, 1'b0})
                                    begin
                                        res.status = STAT_COUNT_ERR;
                                        res_load   = 1'b1;
                                    end
                                    else
                                    begin
                                        word_cnt_next = cnt;
                                        word_k_next   = 4'd0;
                                        state_next    = ST_RD_HI;
                                    end
                                end
                                else
                                begin
                                    res.status = STAT_OK;
                                    res_load   = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_RD_HI:
            begin
                state_next = ST_RD_LO;
            end
            ST_RD_LO:
            begin
                word_hi_next = ram_rdata;
                state_next   = ST_PUT;
            end
            ST_PUT:
            begin
                if (slot_free)
                begin
                    res.status     = STAT_OK;
                    res.reg_word   = {word_hi_reg, ram_rdata};
                    res.word_index = word_k_reg;
                    res.last       = (word_k_reg + 4'd1 == word_cnt_reg);
                    res_load       = 1'b1;
                    if (word_k_reg + 4'd1 == word_cnt_reg)
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        word_k_next = word_k_reg + 4'd1;
                        state_next  = ST_RD_HI;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    // handshake and frame RAM control
    always_comb
    begin
        s_tready  = (state_reg == ST_RECV) && slot_free;
        ram_we    = in_fire && busy_reg && s_tuser == KIND_BYTE &&
                    byte_count_reg < want_len_reg;
        ram_waddr = byte_count_reg;
        ram_re    = (state_reg == ST_RD_HI) || (state_reg == ST_RD_LO);
        ram_raddr = (state_reg == ST_RD_LO) ? hi_addr + STORE_AW'(1) : hi_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RECV;
            busy_reg       <= 1'b0;
            byte_count_reg <= 5'd0;
            crc_reg        <= CRC_INIT;
            elapsed_reg    <= 16'd0;
            want_fn_reg    <= 7'd0;
            want_len_reg   <= 5'd0;
            word_cnt_reg   <= 4'd0;
            word_k_reg     <= 4'd0;
            slave_addr_reg <= SLAVE_ADDR_RST;
            timeout_reg    <= TIMEOUT_RST;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            elapsed_reg    <= elapsed_next;
            want_fn_reg    <= want_fn_next;
            want_len_reg   <= want_len_next;
            word_cnt_reg   <= word_cnt_next;
            word_k_reg     <= word_k_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SLAVE_ADDR: slave_addr_reg <= cfg_data[7:0];
                    CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                    default:        timeout_reg    <= timeout_reg;
                endcase
            end
            if (res_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fs0_reg     <= fs0_next;
        fs1_reg     <= fs1_next;
        fs2_reg     <= fs2_next;
        prev_reg    <= prev_next;
        word_hi_reg <= word_hi_next;
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {4'h0, out_reg.word_index, out_reg.reg_word, out_reg.exception_code};

`ifndef SYNTHESIS
    a_write_only_in_recv: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_RECV)
        else $error("frame RAM written during word run");

    a_idle_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RECV |-> !busy_reg)
        else $error("transaction busy during word run");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |-> word_k_reg < word_cnt_reg)
        else $error("word index past register count");

    a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> byte_count_reg < want_len_reg)
        else $error("byte count reached frame length while busy");

    a_run_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && m_valid_reg |-> m_tready)
        else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for modbus_rtu_response_receiver: drives start, byte
// and tick items, predicts status and register-word results, checks each one.
// Depends on mbrx_pkg and the receiver RTL.
`timescale 1ns / 1ps

import mbrx_pkg::*;

class reply_predictor;
    logic [7:0]  slave_addr;
    logic [15:0] timeout_ticks;
    logic [7:0]  frame [STORE_DEPTH];
    int          byte_cnt;
    logic [15:0] crc;
    logic [15:0] ticks;
    bit          busy;
    logic [6:0]  want_fn;
    int          want_len;
    result_t     expected_q [$];
    int          errors;

    function new();
        slave_addr    = SLAVE_ADDR_RST;
        timeout_ticks = TIMEOUT_RST;
        byte_cnt      = 0;
        crc           = CRC_INIT;
        ticks         = 0;
        busy          = 0;
        want_fn       = 0;
        want_len      = 0;
        errors        = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
        logic [15:0] r;
        r = c ^ {8'h00, d};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    function void write_reg(logic idx, logic [15:0] v);
        if (idx == CFG_SLAVE_ADDR)
            slave_addr = v[7:0];
        else
            timeout_ticks = v;
    endfunction

    function void close_with(logic [2:0] st, logic [7:0] exc);
        busy = 0;
        expected_q.push_back({st, exc, 16'h0000, 4'h0, 1'b1});
    endfunction

    function void take_item(logic [1:0] kind, logic [7:0] b, logic [6:0] fn,
                            logic [4:0] len_in);
        int i;
        int got;
        int needed;
        int regs;
        if (kind == KIND_START)
        begin
            want_len = (len_in < EXC_LEN) ? EXC_LEN : (len_in > MAX_LEN) ? MAX_LEN : len_in;
            want_fn  = fn;
            byte_cnt = 0;
            crc      = CRC_INIT;
            ticks    = 0;
            busy     = 1;
            return;
        end
        if (!busy)
            return;
        if (kind == KIND_TICK)
        begin
            if (ticks != TICK_MAX)
                ticks++;
            if (ticks >= timeout_ticks)
                close_with(STAT_TIMEOUT, 8'h00);
            return;
        end
        if (kind != KIND_BYTE)
            return;

        i = byte_cnt;
        if (i >= want_len || i >= STORE_DEPTH)
        begin
            close_with(STAT_MISMATCH, 8'h00);
            return;
        end
        frame[i] = b;
        got      = i + 1;
        byte_cnt = got;
        if (got == 2 && (frame[0] != slave_addr ||
                         (frame[1] != {1'b0, want_fn} && frame[1] != {1'b1, want_fn})))
        begin
            close_with(STAT_MISMATCH, 8'h00);
            return;
        end
        needed = (got >= 2 && frame[1] == {1'b1, want_fn}) ? EXC_LEN : want_len;
        if (i + 2 < needed)
            crc = crc_step(crc, b);
        if (got != needed)
            return;

        if (frame[needed-2] != crc[7:0] || frame[needed-1] != crc[15:8])
            close_with(STAT_CRC_ERR, 8'h00);
        else if (frame[1][7])
            close_with(STAT_EXCEPTION, frame[2]);
        else if (want_fn == FN_READ_HOLDING || want_fn == FN_READ_INPUT)
        begin
            regs = (want_len - 5) / 2;
            if (regs == 0 || regs > MAX_REGS || frame[2] != 8'(regs * 2))
                close_with(STAT_COUNT_ERR, 8'h00);
            else
            begin
                busy = 0;
                for (int k = 0; k < regs; k++)
                    expected_q.push_back({STAT_OK, 8'h00, frame[3+2*k], frame[4+2*k],
                                          4'(k), 1'(k == regs - 1)});
            end
        end
        else
            close_with(STAT_OK, 8'h00);
    endfunction

    function void check_reply(result_t seen);
        result_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result: status %0d exc %h word %h index %0d last %b",
                     $time, seen.status, seen.exception_code, seen.reg_word,
                     seen.word_index, seen.last);
            return;
        end
        want = expected_q.pop_front();
        if (seen !== want)
        begin
            errors++;
            $display("%0t: expected status %0d exc %h word %h index %0d last %b",
                     $time, want.status, want.exception_code, want.reg_word,
                     want.word_index, want.last);
            $display("%0t:      got status %0d exc %h word %h index %0d last %b",
                     $time, seen.status, seen.exception_code, seen.reg_word,
                     seen.word_index, seen.last);
        end
    endfunction
endclass

module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    reply_predictor tracker;
    result_t        seen_reply;
    int             items_sent;
    int             burst_left;
    bit             steady;
    int             tick_pct;
    int             cycle_count;
    int             stall_period;
    int             stall_len;
    int             stall_phase;

    modbus_rtu_response_receiver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                tracker.take_item(s_tuser, s_tdata[7:0], s_tdata[14:8], s_tdata[19:15]);
            if (m_tvalid && m_tready)
            begin
                seen_reply = {m_tuser, m_tdata[7:0], m_tdata[23:8], m_tdata[27:24], m_tlast};
                tracker.check_reply(seen_reply);
            end
        end
    end

    // receiver stalls on a periodic pattern that is re-picked now and then
    always @(negedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_period = $urandom_range(2, 9);
            stall_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, stall_period - 1);
            stall_phase  = stall_period * $urandom_range(4, 12);
        end
        stall_phase--;
        m_tready <= (stall_phase % stall_period) >= stall_len;
    end

    task automatic push_item(input logic [1:0] kind, input logic [7:0] b,
                             input logic [6:0] fn, input logic [4:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, len, fn, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic push_noise();
        push_item(2'($urandom), 8'($urandom), 7'($urandom), 5'($urandom));
    endtask

    task automatic send_bytes(input logic [7:0] bytes [$]);
        foreach (bytes[k])
        begin
            if ($urandom_range(0, 99) < tick_pct)
                push_item(KIND_TICK, 8'($urandom), 7'($urandom), 5'($urandom));
            if ($urandom_range(0, 99) < 2)
                push_noise();
            push_item(KIND_BYTE, bytes[k], 7'($urandom), 5'($urandom));
        end
    endtask

    task automatic seal(ref logic [7:0] bytes [$]);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (bytes[k])
            c = crc16_byte(c, bytes[k]);
        bytes.push_back(c[7:0]);
        bytes.push_back(c[15:8]);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.write_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // finish any armed transaction with a bad address, then let the block drain
    task automatic close_out();
        if (tracker.busy)
        begin
            push_item(KIND_START, 8'($urandom), 7'($urandom), 5'($urandom));
            push_item(KIND_BYTE, ~tracker.slave_addr, 7'($urandom), 5'($urandom));
            push_item(KIND_BYTE, 8'($urandom), 7'($urandom), 5'($urandom));
        end
        s_tvalid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic run_transaction(input int pick, input int force_regs);
        logic [7:0] q [$];
        logic [7:0] addr;
        logic [7:0] b1;
        logic [6:0] fn;
        logic [4:0] len_field;
        int         sel;
        int         nregs;
        int         len;
        int         cut;
        addr   = tracker.slave_addr;
        sel    = (pick < 0) ? $urandom_range(0, 99) : pick;
        steady = ($urandom_range(0, 4) == 0);
        q      = {};
        if (sel < 48 || (sel >= 78 && sel < 82))
        begin
            fn    = $urandom_range(0, 1) ? FN_READ_HOLDING : FN_READ_INPUT;
            nregs = (force_regs > 0) ? force_regs :
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_REGS) :
                    $urandom_range(1, 4);
            len   = 5 + 2 * nregs;
            q.push_back(addr);
            q.push_back({1'b0, fn});
            q.push_back(8'(2 * nregs));
            if (sel >= 40 && sel < 48)
                q[2] = q[2] ^ (8'h01 << $urandom_range(0, 7));
            repeat (2 * nregs) q.push_back(8'($urandom));
            if (len < STORE_DEPTH && $urandom_range(0, 3) == 0)
            begin
                len++;
                q.push_back(8'($urandom));
            end
            len_field = 5'(len);
            seal(q);
        end
        else if (sel < 68 || (sel >= 82 && sel < 86))
        begin
            do
                fn = 7'($urandom_range(1, 127));
            while (fn == FN_READ_HOLDING || fn == FN_READ_INPUT);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 29) : $urandom_range(5, 10);
            q.push_back(addr);
            q.push_back({1'b0, fn});
            repeat (len - 4) q.push_back(8'($urandom));
            len_field = 5'(len);
            seal(q);
        end
        else if (sel < 78)
        begin
            fn        = 7'($urandom_range(1, 127));
            len_field = 5'($urandom);
            q.push_back(addr);
            q.push_back({1'b1, fn});
            q.push_back(8'($urandom));
            seal(q);
        end
        else if (sel < 94)
        begin
            fn        = 7'($urandom_range(1, 127));
            len_field = 5'($urandom_range(5, 29));
            if ($urandom_range(0, 1))
            begin
                q.push_back(addr ^ 8'($urandom_range(1, 255)));
                q.push_back({1'b0, fn});
            end
            else
            begin
                do
                    b1 = 8'($urandom);
                while (b1[6:0] == fn);
                q.push_back(addr);
                q.push_back(b1);
            end
            repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
        end
        else
        begin
            // abandoned frame: cut short, then ticks or the next start end it
            fn        = 7'($urandom_range(1, 127));
            len       = $urandom_range(5, 29);
            len_field = 5'(len);
            cut       = $urandom_range(0, len - 1);
            if (cut > 0)
                q.push_back(addr);
            if (cut > 1)
                q.push_back({1'b0, fn});
            while (q.size() < cut)
                q.push_back(8'($urandom));
        end

        if (sel >= 78 && sel < 86)
        begin
            cut = $urandom_range(2, q.size() - 1);
            q[cut] = q[cut] ^ (8'h01 << $urandom_range(0, 7));
        end

        push_item(KIND_START, 8'($urandom), fn, len_field);
        send_bytes(q);
        if (sel >= 94 && tick_pct > 0 && tracker.timeout_ticks <= 64)
            repeat (tracker.timeout_ticks + 1)
                push_item(KIND_TICK, 8'($urandom), 7'($urandom), 5'($urandom));
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) push_noise();
    endtask

    task automatic run_phase(input int target);
        while (items_sent < target)
            run_transaction(-1, 0);
    endtask

    task automatic directed_items();
        logic [7:0] q [$];
        steady = 1;
        push_item(KIND_BYTE, 8'hA5, 7'h7F, 5'h1F);
        push_item(KIND_TICK, 8'h00, 7'h00, 5'h00);
        push_item(KIND_UNUSED, 8'hFF, 7'h7F, 5'h1F);

        // read with a clamped length of five has no words
        q = {SLAVE_ADDR_RST, 8'h03, 8'h00};
        seal(q);
        push_item(KIND_START, 8'h00, FN_READ_HOLDING, 5'd0);
        send_bytes(q);

        // exception frame, length above the store clamped
        q = {SLAVE_ADDR_RST, 8'h84, 8'h02};
        seal(q);
        push_item(KIND_START, 8'h00, FN_READ_INPUT, 5'd31);
        send_bytes(q);

        // restart while busy, unknown kind in the middle of a frame
        push_item(KIND_START, 8'h00, 7'h10, 5'd8);
        push_item(KIND_BYTE, SLAVE_ADDR_RST, 7'h00, 5'd0);
        push_item(KIND_BYTE, 8'h10, 7'h00, 5'd0);
        q = {SLAVE_ADDR_RST, 8'h7F, 8'hAA};
        seal(q);
        push_item(KIND_START, 8'h00, 7'h7F, 5'd5);
        push_item(KIND_BYTE, q[0], 7'h00, 5'd0);
        push_item(KIND_UNUSED, 8'h55, 7'h2A, 5'h0A);
        q.delete(0);
        send_bytes(q);
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = 1'b0;
        cfg_data     = '0;
        items_sent   = 0;
        burst_left   = 0;
        steady       = 0;
        tick_pct     = 3;
        cycle_count  = 0;
        stall_phase  = 0;
        stall_period = 1;
        stall_len    = 0;
        tracker      = new();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_items();
        run_phase(110);
        close_out();

        write_reg(CFG_SLAVE_ADDR, {8'($urandom), 8'd1});
        write_reg(CFG_TIMEOUT, 16'd1);
        tick_pct = 2;
        run_phase(165);
        close_out();

        write_reg(CFG_SLAVE_ADDR, {8'($urandom), 8'd247});
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        tick_pct = 6;
        run_transaction(5, MAX_REGS);
        run_phase(265);
        close_out();

        write_reg(CFG_SLAVE_ADDR, {8'($urandom), 8'($urandom_range(2, 246))});
        write_reg(CFG_TIMEOUT, 16'($urandom_range(5, 60)));
        tick_pct = 8;
        run_phase(360);
        close_out();

        if (tracker.errors == 0 && tracker.expected_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
